[rtl/srdl_pkg.sv]
// Shared constants, codes and types of the survey request dedup limiter.
`default_nettype none
package srdl_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam int LEDGER_W = 32;
  localparam int ID_W     = 64;
  localparam int WINDOW_W = 16;
  localparam int LIMIT_W  = 8;

  localparam int IN_DATA_W  = 200;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [2:0] {
    KIND_REQUEST  = 3'd0,
    KIND_RESPONSE = 3'd1,
    KIND_START    = 3'd2,
    KIND_STOP     = 3'd3,
    KIND_CLEAR    = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    RSN_OK        = 4'd0,
    RSN_WINDOW    = 4'd1,
    RSN_SR_LIMIT  = 4'd2,
    RSN_SD_LIMIT  = 4'd3,
    RSN_DUPLICATE = 4'd4,
    RSN_UNSEEN    = 4'd5,
    RSN_ACTIVE    = 4'd6,
    RSN_EXTERNAL  = 4'd7,
    RSN_FULL      = 4'd8
  } reason_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW  = 2'd0,
    CFG_LIMIT   = 2'd1,
    CFG_SELF_ID = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]     surveyed;
    logic [ID_W-1:0]     surveyor;
    logic [LEDGER_W-1:0] ledger;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic load;
    logic scan_start;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic needs_scan;
    logic scan_done;
    logic out_busy;
  } dp_stat_t;

endpackage
`default_nettype wire

[rtl/srdl_ram.sv]
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module srdl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

[rtl/srdl_ctrl.sv]
// Controller state machine: sequences capture, table scan and result.
`default_nettype none
module srdl_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire srdl_pkg::dp_stat_t stat,
  output srdl_pkg::ctrl_cmd_t     cmd
);
  import srdl_pkg::*;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat.needs_scan) begin
          cmd.scan_start = 1'b1;
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_SCAN: begin
        if (stat.scan_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[rtl/srdl_dp.sv]
// Datapath: config registers, entry table, scan accumulators and result register.
`default_nettype none
module srdl_dp (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire srdl_pkg::ctrl_cmd_t             cmd,
  output srdl_pkg::dp_stat_t                   stat,
  input  wire logic                            cfg_valid,
  input  wire logic [srdl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [srdl_pkg::ID_W-1:0]       cfg_data,
  input  wire logic [2:0]                      in_kind,
  input  wire logic [srdl_pkg::IN_DATA_W-1:0]  in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [srdl_pkg::OUT_DATA_W-1:0]      out_data
);
  import srdl_pkg::*;

  // Configuration
  logic [WINDOW_W-1:0] win_r;
  logic [LIMIT_W-1:0]  limit_r;
  logic [ID_W-1:0]     self_r;

  // Captured item
  kind_t               kind_r;
  logic [LEDGER_W-1:0] led_r, local_r;
  logic [ID_W-1:0]     sr_r, sd_r;
  logic                ext_r, active_r;

  // Table flags
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [TABLE_ENTRIES-1:0] seen_r, seen_nxt;
  logic [TABLE_ENTRIES-1:0] head_r, head_nxt;

  // Scan state
  logic [CNT_W-1:0] cnt_r;
  logic             act_r;
  logic             p_valid_r;
  logic [IDX_W-1:0] p_idx_r;

  // Accumulators
  logic             led_known_r, sr_known_r, dup_r, match_r, free_r;
  logic [CNT_W-1:0] n_sr_r, n_sd_r;
  logic [IDX_W-1:0] free_idx_r, match_idx_r;

  // Result register
  logic          out_valid_r;
  logic          out_acc_r;
  reason_t       out_rsn_r;

  entry_t ent_rd, ent_wr;
  logic   ram_we;
  logic   win_ok, is_self;
  logic   fin_acc;
  reason_t fin_rsn;
  logic   commit_req, commit_resp;
  logic [LEDGER_W:0] lo_sum, up_sum, clr_sum;
  logic [WINDOW_W-1:0] up_w;
  logic   hit_led, hit_sr;

  srdl_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx_r),
    .wdata (ent_wr),
    .raddr (cnt_r[IDX_W-1:0]),
    .rdata (ent_rd)
  );

  // Window check on the captured item, scan hit compares, clear age sum and self-ID match
  always_comb begin
    up_w   = (win_r == '0) ? WINDOW_W'(1) : win_r;
    lo_sum = {1'b0, led_r} + {{(LEDGER_W+1-WINDOW_W){1'b0}}, win_r};
    up_sum = {1'b0, local_r} + {{(LEDGER_W+1-WINDOW_W){1'b0}}, up_w};
    win_ok = (lo_sum >= {1'b0, local_r}) && ({1'b0, led_r} <= up_sum);
    clr_sum = {1'b0, ent_rd.ledger} + {{(LEDGER_W+1-WINDOW_W){1'b0}}, win_r};
    hit_led = valid_r[p_idx_r] && (ent_rd.ledger == led_r);
    hit_sr  = hit_led && (ent_rd.surveyor == sr_r);
    is_self = (sr_r == self_r);
  end

  // Final decision from the scan results
  always_comb begin
    fin_acc = 1'b0;
    fin_rsn = RSN_OK;
    commit_req = 1'b0;
    commit_resp = 1'b0;
    case (kind_r)
      KIND_CLEAR: fin_acc = 1'b1;
      KIND_REQUEST: begin
        if (!win_ok) begin
          fin_rsn = RSN_WINDOW;
        end else if (led_known_r && !sr_known_r && !is_self &&
                     n_sr_r >= CNT_W'(limit_r)) begin
          fin_rsn = RSN_SR_LIMIT;
        end else if (led_known_r && sr_known_r && !is_self &&
                     n_sd_r >= CNT_W'(limit_r)) begin
          fin_rsn = RSN_SD_LIMIT;
        end else if (led_known_r && sr_known_r && dup_r) begin
          fin_rsn = RSN_DUPLICATE;
        end else if (!free_r) begin
          fin_rsn = RSN_FULL;
        end else if (!ext_r) begin
          fin_rsn = RSN_EXTERNAL;
        end else begin
          fin_acc = 1'b1;
          commit_req = 1'b1;
        end
      end
      KIND_RESPONSE: begin
        if (!win_ok) begin
          fin_rsn = RSN_WINDOW;
        end else if (!match_r) begin
          fin_rsn = RSN_UNSEEN;
        end else if (seen_r[match_idx_r]) begin
          fin_rsn = RSN_DUPLICATE;
        end else if (!ext_r) begin
          fin_rsn = RSN_EXTERNAL;
        end else begin
          fin_acc = 1'b1;
          commit_resp = 1'b1;
        end
      end
      KIND_START, KIND_STOP: begin
        if (!win_ok) begin
          fin_rsn = RSN_WINDOW;
        end else if (kind_r == KIND_START && active_r) begin
          fin_rsn = RSN_ACTIVE;
        end else if (!ext_r) begin
          fin_rsn = RSN_EXTERNAL;
        end else begin
          fin_acc = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // New entry for a recorded request
  always_comb begin
    ent_wr.ledger   = led_r;
    ent_wr.surveyor = sr_r;
    ent_wr.surveyed = sd_r;
    ram_we = cmd.finish && commit_req;
  end

  // Table flag updates: clear during scan, record or answer at finish
  always_comb begin
    valid_nxt = valid_r;
    seen_nxt  = seen_r;
    head_nxt  = head_r;
    if (p_valid_r && kind_r == KIND_CLEAR && valid_r[p_idx_r] &&
        clr_sum < {1'b0, led_r}) begin
      valid_nxt[p_idx_r] = 1'b0;
      seen_nxt[p_idx_r]  = 1'b0;
    end
    if (cmd.finish && commit_req) begin
      valid_nxt[free_idx_r] = 1'b1;
      seen_nxt[free_idx_r]  = 1'b0;
      head_nxt[free_idx_r]  = !sr_known_r;
    end
    if (cmd.finish && commit_resp) begin
      seen_nxt[match_idx_r] = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= WINDOW_W'(6);
      limit_r     <= LIMIT_W'(10);
      self_r      <= '0;
      valid_r     <= '0;
      seen_r      <= '0;
      act_r       <= 1'b0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_WINDOW:  win_r   <= cfg_data[WINDOW_W-1:0];
          CFG_LIMIT:   limit_r <= cfg_data[LIMIT_W-1:0];
          CFG_SELF_ID: self_r  <= cfg_data;
          default: ;
        endcase
      end
      valid_r <= valid_nxt;
      seen_r  <= seen_nxt;
      // Scan active flag and the valid flag of its read pipeline
      if (cmd.scan_start) begin
        act_r <= 1'b1;
      end else if (act_r && cnt_r == CNT_W'(TABLE_ENTRIES - 1)) begin
        act_r <= 1'b0;
      end
      p_valid_r <= act_r;
      // Hold result until the beat is taken
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    if (cmd.load) begin
      kind_r   <= kind_t'(in_kind);
      led_r    <= in_data[31:0];
      local_r  <= in_data[63:32];
      sr_r     <= in_data[127:64];
      sd_r     <= in_data[191:128];
      ext_r    <= in_data[192];
      active_r <= in_data[193];
    end
    if (cmd.scan_start) begin
      cnt_r       <= '0;
      led_known_r <= 1'b0;
      sr_known_r  <= 1'b0;
      dup_r       <= 1'b0;
      match_r     <= 1'b0;
      free_r      <= 1'b0;
      n_sr_r      <= '0;
      n_sd_r      <= '0;
    end else begin
      if (act_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (p_valid_r) begin
        if (!valid_r[p_idx_r] && !free_r) begin
          free_r     <= 1'b1;
          free_idx_r <= p_idx_r;
        end
        if (hit_led) begin
          led_known_r <= 1'b1;
          if (head_r[p_idx_r]) begin
            n_sr_r <= n_sr_r + CNT_W'(1);
          end
        end
        if (hit_sr) begin
          sr_known_r <= 1'b1;
          n_sd_r <= n_sd_r + CNT_W'(1);
          if (ent_rd.surveyed == sd_r) begin
            dup_r       <= 1'b1;
            match_r     <= 1'b1;
            match_idx_r <= p_idx_r;
          end
        end
      end
    end
    p_idx_r <= cnt_r[IDX_W-1:0];
    if (cmd.finish) begin
      out_acc_r <= fin_acc;
      out_rsn_r <= fin_rsn;
    end
  end

  // Status and outputs
  always_comb begin
    stat.needs_scan = (kind_r == KIND_CLEAR) ||
                      ((kind_r == KIND_REQUEST || kind_r == KIND_RESPONSE) && win_ok);
    stat.scan_done  = !act_r && !p_valid_r;
    stat.out_busy   = out_valid_r && !out_ready;
    out_valid = out_valid_r;
    out_data  = {3'b000, out_rsn_r, out_acc_r};
  end

endmodule
`default_nettype wire

[rtl/survey_request_dedup_limiter_unit.sv]
// Top level of the survey request dedup limiter.
//
// Channels: in_ carries one survey message per beat (kind in in_tuser, the
// other fields in in_tdata); out_ returns one beat per message with accepted
// and reason; cfg_ writes ledger_window (0), request_limit (1) or self_id (2)
// and is always ready.
// Sequence: start, stop, unused kinds and out-of-window requests and responses
// skip the table scan and go from the check step to the finish step. Other
// requests and responses and all clear commands walk the whole entry table
// through the RAM read port, one entry per cycle, before the finish step.
// Throughput: one message at a time; in_tready is high only while idle, and
// the next beat may be taken while the previous result still waits on out_.
// Reset (rst_n low, synchronous) empties the table, restores the register
// defaults and drops any pending result; no clearing pass is needed.
// When the receiver stalls the result is held and the next message waits
// in the finish step until the result register is free.
`default_nettype none
module survey_request_dedup_limiter_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // [31:0] ledger_num, [63:32] local_ledger, [127:64] surveyor_id,
  // [191:128] surveyed_id, [192] external_ok, [193] survey_active
  input  wire logic [srdl_pkg::IN_DATA_W-1:0]  in_tdata,
  // [2:0] kind
  input  wire logic [2:0]                      in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // [0] accepted, [4:1] reason
  output logic [srdl_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [srdl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [srdl_pkg::ID_W-1:0]       cfg_data
);
  import srdl_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  srdl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  srdl_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_kind   (in_tuser),
    .in_data   (in_tdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule
`default_nettype wire

[rtl/srdl_checker.sv]
// Port-level checker for the limiter and its bind to the top level.
`default_nettype none
module srdl_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [srdl_pkg::OUT_DATA_W-1:0] out_tdata
);
  import srdl_pkg::*;

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result beat changed");

  // One message in flight: no input beat right after an accepted one
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a message is in flight");

  // Accepted results carry reason ok
  a_acc_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[4:1] == RSN_OK)
    else $error("accepted result with nonzero reason");

  // Reset drops any pending result
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind survey_request_dedup_limiter_unit srdl_checker u_srdl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
